// ----- rtl/core/hpc_pkg.sv -----
// Shared types, codes and constants of the hand pose classifier.
package hpc_pkg;

  // Default coordinate width: signed Q12.4 millimetres
  localparam int COORD_BITS_DEF = 16;

  // Threshold registers are signed Q1.15
  localparam int THR_W = 16;
  // Squared threshold magnitude is at most 2^30
  localparam int TSQ_W = 2 * (THR_W - 1) + 1;
  // Scale of a squared Q1.15 cosine: 32768^2
  localparam int COS_SHIFT = 2 * (THR_W - 1);

  // Digit width of the serial multiplier
  localparam int MUL_DIGIT = 16;

  localparam int FINGERS = 4;
  localparam logic [1:0] FINGER_PINKY = 2'd3;

  localparam logic BONE_METACARPAL   = 1'b0;
  localparam logic BONE_INTERMEDIATE = 1'b1;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] REG_OPEN_COS   = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_CLOSED_COS = 1'b1;

  localparam logic signed [THR_W-1:0] OPEN_COS_RESET   = 16'sd26214;
  localparam logic signed [THR_W-1:0] CLOSED_COS_RESET = -16'sd16384;

  typedef enum logic [2:0] {
    GEST_NONE,
    GEST_OPEN,
    GEST_CLOSED,
    GEST_OPEN_INDEX,
    GEST_CURVED_INDEX,
    GEST_INDEX_MIDDLE,
    GEST_INDEX_MIDDLE_RING,
    GEST_PINKY
  } gesture_t;

  // Operand sets of the shared serial multiplier
  typedef enum logic [1:0] {
    MUL_LEN,     // |a|^2 * |b|^2
    MUL_DOT,     // dot^2
    MUL_OPEN,    // open threshold^2 * length product
    MUL_CLOSED   // closed threshold^2 * length product
  } mul_op_t;

  // Operand selection of the three lane multipliers
  typedef enum logic [1:0] {
    LANE_CROSS,  // base * dir
    LANE_BASE,   // base * base
    LANE_DIR     // dir * dir
  } lane_sel_t;

  typedef struct packed {
    logic      load_base;
    logic      load_item;
    lane_sel_t lane_sel;
    logic      load_dot;
    logic      load_la;
    logic      load_lb;
    logic      mul_start;
    mul_op_t   mul_op;
    logic      mul_capture;
    logic      decide;
  } hpc_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic pinky;
  } hpc_stat_t;

endpackage

// ----- rtl/core/hpc_serial_mul.sv -----
// Digit-serial unsigned multiplier, most significant digit of b first.
module hpc_serial_mul #(
  parameter int A_W   = 68,
  parameter int B_W   = 34,
  parameter int DIGIT = hpc_pkg::MUL_DIGIT
) (
  input  logic                                              clk,
  input  logic                                              rst,
  input  logic                                              start,
  input  logic [A_W-1:0]                                    a,
  input  logic [B_W-1:0]                                    b,
  output logic                                              busy,
  output logic [A_W+((B_W+DIGIT-1)/DIGIT)*DIGIT-1:0]        product
);

  localparam int STEPS = (B_W + DIGIT - 1) / DIGIT;
  localparam int BWP   = STEPS * DIGIT;
  localparam int PW    = A_W + BWP;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [A_W-1:0]       a_r;
  logic [BWP-1:0]       b_r;
  logic [PW-1:0]        acc;
  logic [CNT_W-1:0]     count;
  logic [A_W+DIGIT-1:0] part;

  // Multiply the wide operand by the current top digit
  assign part    = a_r * b_r[BWP-1 -: DIGIT];
  assign product = acc;

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      count <= count + 1'b1;
      if (count == CNT_W'(STEPS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift and accumulate one digit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= BWP'(b);
      acc <= '0;
    end else if (busy) begin
      acc <= (acc << DIGIT) + PW'(part);
      b_r <= b_r << DIGIT;
    end
  end

endmodule

// ----- rtl/core/hpc_dpath.sv -----
// Datapath: bone directions, dot and length sums, wide compares, flags and result.
module hpc_dpath #(
  parameter int COORD_BITS = hpc_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  hpc_pkg::hpc_cmd_t                     cmd,
  output hpc_pkg::hpc_stat_t                    stat,
  input  logic                                  cfg_we,
  input  logic [hpc_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [hpc_pkg::THR_W-1:0]             cfg_data,
  input  logic [1:0]                            finger_index,
  input  logic signed [COORD_BITS-1:0]          start_x,
  input  logic signed [COORD_BITS-1:0]          start_y,
  input  logic signed [COORD_BITS-1:0]          start_z,
  input  logic signed [COORD_BITS-1:0]          end_x,
  input  logic signed [COORD_BITS-1:0]          end_y,
  input  logic signed [COORD_BITS-1:0]          end_z,
  output logic [2:0]                            gesture_code,
  output logic [hpc_pkg::FINGERS-1:0]           open_mask,
  output logic [hpc_pkg::FINGERS-1:0]           closed_mask
);

  import hpc_pkg::*;

  localparam int DW     = COORD_BITS + 1;        // direction component
  localparam int PROD_W = 2 * DW;                // one lane product
  localparam int SW     = 2 * COORD_BITS + 2;    // squared length / dot magnitude
  localparam int SUM_W  = SW + 1;                // signed dot product
  localparam int AW     = 2 * SW;                // length product
  localparam int BW     = (SW > TSQ_W) ? SW : TSQ_W;
  localparam int PW     = AW + ((BW + MUL_DIGIT - 1) / MUL_DIGIT) * MUL_DIGIT;

  logic signed [COORD_BITS-1:0] start_c [3];
  logic signed [COORD_BITS-1:0] end_c [3];
  logic signed [DW-1:0]         dir_in [3];
  logic signed [DW-1:0]         base [3];
  logic signed [DW-1:0]         dir_r [3];
  logic signed [DW-1:0]         op_a [3];
  logic signed [DW-1:0]         op_b [3];
  logic signed [PROD_W-1:0]     prod [3];
  logic signed [SUM_W-1:0]      lane_sum;
  logic signed [SUM_W-1:0]      dot_r;
  logic signed [SUM_W-1:0]      dot_neg;
  logic [SW-1:0]                dot_mag;
  logic [SW-1:0]                la_r;
  logic [SW-1:0]                lb_r;
  logic [1:0]                   finger_r;

  logic signed [THR_W-1:0]      open_t;
  logic signed [THR_W-1:0]      closed_t;
  logic signed [THR_W:0]        open_ext;
  logic signed [THR_W:0]        closed_ext;
  logic [THR_W:0]               open_mag;
  logic [THR_W:0]               closed_mag;
  logic [2*THR_W+1:0]           open_sq;
  logic [2*THR_W+1:0]           closed_sq;

  logic [AW-1:0]                mul_a;
  logic [BW-1:0]                mul_b;
  logic                         mul_busy;
  logic [PW-1:0]                mul_prod;
  logic [AW-1:0]                p_r;
  logic [PW-1:0]                d2_r;
  logic [PW-1:0]                ro_r;
  logic [PW-1:0]                rc_r;
  logic [PW-1:0]                lhs;

  logic                         d_neg;
  logic                         d_pos;
  logic                         to_neg;
  logic                         tc_pos;
  logic                         open_hit;
  logic                         closed_hit;
  logic                         valid_len;
  logic                         op;
  logic                         cl;
  logic [FINGERS-1:0]           open_flags;
  logic [FINGERS-1:0]           closed_flags;
  logic [FINGERS-1:0]           open_new;
  logic [FINGERS-1:0]           closed_new;
  logic [FINGERS-1:0]           finger_bit;
  gesture_t                     gest_r;
  logic [FINGERS-1:0]           open_out;
  logic [FINGERS-1:0]           closed_out;

  // Pick the gesture by priority from the two flag masks
  function automatic gesture_t classify(input logic [FINGERS-1:0] o,
                                        input logic [FINGERS-1:0] c);
    gesture_t g;
    priority if (o == 4'b1111)                 g = GEST_OPEN;
    else if (c == 4'b1111)                     g = GEST_CLOSED;
    else if (o == 4'b0001)                     g = GEST_OPEN_INDEX;
    else if (o == 4'b0000 && !c[0])            g = GEST_CURVED_INDEX;
    else if (o == 4'b0011)                     g = GEST_INDEX_MIDDLE;
    else if (o == 4'b0111)                     g = GEST_INDEX_MIDDLE_RING;
    else if (o[2:0] == 3'b000 && !c[3])        g = GEST_PINKY;
    else                                       g = GEST_NONE;
    return g;
  endfunction

  // Bone direction is end minus start
  assign start_c[0] = start_x;
  assign start_c[1] = start_y;
  assign start_c[2] = start_z;
  assign end_c[0]   = end_x;
  assign end_c[1]   = end_y;
  assign end_c[2]   = end_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dir_in[i] = DW'(end_c[i]) - DW'(start_c[i]);
    end
  end

  // Select lane operands
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      op_a[i] = base[i];
      op_b[i] = dir_r[i];
      unique case (cmd.lane_sel)
        LANE_CROSS: begin
          op_a[i] = base[i];
          op_b[i] = dir_r[i];
        end
        LANE_BASE: begin
          op_a[i] = base[i];
          op_b[i] = base[i];
        end
        LANE_DIR: begin
          op_a[i] = dir_r[i];
          op_b[i] = dir_r[i];
        end
        default: begin
          op_a[i] = base[i];
          op_b[i] = dir_r[i];
        end
      endcase
    end
  end

  // Add the three registered lane products
  assign lane_sum = SUM_W'(prod[0]) + SUM_W'(prod[1]) + SUM_W'(prod[2]);
  assign dot_neg  = -dot_r;
  assign dot_mag  = dot_r[SUM_W-1] ? dot_neg[SW-1:0] : dot_r[SW-1:0];

  // Square the threshold magnitudes
  assign open_ext   = (THR_W + 1)'(open_t);
  assign closed_ext = (THR_W + 1)'(closed_t);
  assign open_mag   = open_ext[THR_W] ? (THR_W + 1)'(0) - open_ext : open_ext;
  assign closed_mag = closed_ext[THR_W] ? (THR_W + 1)'(0) - closed_ext : closed_ext;
  assign open_sq    = open_mag * open_mag;
  assign closed_sq  = closed_mag * closed_mag;

  // Route operands to the shared multiplier
  always_comb begin
    mul_a = AW'(la_r);
    mul_b = BW'(lb_r);
    unique case (cmd.mul_op)
      MUL_LEN: begin
        mul_a = AW'(la_r);
        mul_b = BW'(lb_r);
      end
      MUL_DOT: begin
        mul_a = AW'(dot_mag);
        mul_b = BW'(dot_mag);
      end
      MUL_OPEN: begin
        mul_a = p_r;
        mul_b = BW'(open_sq[TSQ_W-1:0]);
      end
      MUL_CLOSED: begin
        mul_a = p_r;
        mul_b = BW'(closed_sq[TSQ_W-1:0]);
      end
      default: begin
        mul_a = AW'(la_r);
        mul_b = BW'(lb_r);
      end
    endcase
  end

  hpc_serial_mul #(
    .A_W   (AW),
    .B_W   (BW),
    .DIGIT (MUL_DIGIT)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .busy    (mul_busy),
    .product (mul_prod)
  );

  // Resolve the cosine tests by signs, then by the squared compare
  assign lhs    = d2_r << COS_SHIFT;
  assign d_neg  = dot_r[SUM_W-1];
  assign d_pos  = !d_neg && (dot_r != '0);
  assign to_neg = open_t[THR_W-1];
  assign tc_pos = !closed_t[THR_W-1] && (closed_t != '0);

  always_comb begin
    priority if (!d_neg && to_neg) open_hit = 1'b1;
    else if (d_neg && !to_neg)     open_hit = 1'b0;
    else if (!d_neg)               open_hit = lhs > ro_r;
    else                           open_hit = lhs < ro_r;
  end

  // Closed is the open test on the negated dot and threshold
  always_comb begin
    priority if (!d_pos && tc_pos) closed_hit = 1'b1;
    else if (d_pos && !tc_pos)     closed_hit = 1'b0;
    else if (!d_pos)               closed_hit = lhs > rc_r;
    else                           closed_hit = lhs < rc_r;
  end

  // A zero-length bone makes the finger neither open nor closed
  assign valid_len  = (la_r != '0) && (lb_r != '0);
  assign op         = valid_len && open_hit;
  assign cl         = valid_len && closed_hit;
  assign finger_bit = FINGERS'(1) << finger_r;
  assign open_new   = (open_flags & ~finger_bit) | (FINGERS'(op) << finger_r);
  assign closed_new = (closed_flags & ~finger_bit) | (FINGERS'(cl) << finger_r);

  assign stat.mul_busy = mul_busy;
  assign stat.pinky    = (finger_r == FINGER_PINKY);

  // Hold configuration, base direction and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      open_t       <= OPEN_COS_RESET;
      closed_t     <= CLOSED_COS_RESET;
      open_flags   <= '0;
      closed_flags <= '0;
      for (int i = 0; i < 3; i++) begin
        base[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_OPEN_COS:   open_t   <= signed'(cfg_data);
          REG_CLOSED_COS: closed_t <= signed'(cfg_data);
          default: ;
        endcase
      end
      if (cmd.load_base) begin
        for (int i = 0; i < 3; i++) begin
          base[i] <= dir_in[i];
        end
      end
      if (cmd.decide) begin
        if (stat.pinky) begin
          // Drop the finished hand
          open_flags   <= '0;
          closed_flags <= '0;
          for (int i = 0; i < 3; i++) begin
            base[i] <= '0;
          end
        end else begin
          open_flags   <= open_new;
          closed_flags <= closed_new;
        end
      end
    end
  end

  // Advance the arithmetic registers
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      finger_r <= finger_index;
      for (int i = 0; i < 3; i++) begin
        dir_r[i] <= dir_in[i];
      end
    end
    for (int i = 0; i < 3; i++) begin
      prod[i] <= op_a[i] * op_b[i];
    end
    if (cmd.load_dot) dot_r <= lane_sum;
    if (cmd.load_la)  la_r  <= lane_sum[SW-1:0];
    if (cmd.load_lb)  lb_r  <= lane_sum[SW-1:0];
    if (cmd.mul_capture) begin
      unique case (cmd.mul_op)
        MUL_LEN:    p_r  <= mul_prod[AW-1:0];
        MUL_DOT:    d2_r <= mul_prod;
        MUL_OPEN:   ro_r <= mul_prod;
        MUL_CLOSED: rc_r <= mul_prod;
        default: ;
      endcase
    end
    // Load the result register at the end of a hand
    if (cmd.decide && stat.pinky) begin
      gest_r     <= classify(open_new, closed_new);
      open_out   <= open_new;
      closed_out <= closed_new;
    end
  end

  assign gesture_code = gest_r;
  assign open_mask    = open_out;
  assign closed_mask  = closed_out;

endmodule

// ----- rtl/core/hpc_ctrl.sv -----
// Controller: request handshake, sequencing of the datapath, result valid.
module hpc_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               bone_kind,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output hpc_pkg::hpc_cmd_t  cmd,
  input  hpc_pkg::hpc_stat_t stat
);

  import hpc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DOT,
    S_LEN_A,
    S_LEN_B,
    S_SUM_B,
    S_MUL_GO,
    S_MUL_WAIT,
    S_DECIDE
  } state_t;

  state_t  state;
  mul_op_t mul_op;
  logic    accept;
  logic    out_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Decode commands from the state and the accepted request
  always_comb begin
    cmd             = '0;
    cmd.load_base   = accept && (bone_kind == BONE_METACARPAL);
    cmd.load_item   = accept && (bone_kind == BONE_INTERMEDIATE);
    cmd.lane_sel    = LANE_CROSS;
    unique case (state)
      S_LEN_A: cmd.lane_sel = LANE_BASE;
      S_LEN_B: cmd.lane_sel = LANE_DIR;
      default: cmd.lane_sel = LANE_CROSS;
    endcase
    cmd.load_dot    = (state == S_LEN_A);
    cmd.load_la     = (state == S_LEN_B);
    cmd.load_lb     = (state == S_SUM_B);
    cmd.mul_start   = (state == S_MUL_GO);
    cmd.mul_op      = mul_op;
    cmd.mul_capture = (state == S_MUL_WAIT) && !stat.mul_busy;
    cmd.decide      = (state == S_DECIDE) && (!stat.pinky || out_free);
  end

  // Hold state, multiplier step and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mul_op    <= MUL_LEN;
      out_valid <= 1'b0;
    end else begin
      out_valid <= (cmd.decide && stat.pinky) || (out_valid && out_stall);
      unique case (state)
        S_IDLE: begin
          if (accept && bone_kind == BONE_INTERMEDIATE) state <= S_DOT;
        end
        S_DOT:   state <= S_LEN_A;
        S_LEN_A: state <= S_LEN_B;
        S_LEN_B: state <= S_SUM_B;
        S_SUM_B: begin
          mul_op <= MUL_LEN;
          state  <= S_MUL_GO;
        end
        S_MUL_GO: state <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (!stat.mul_busy) begin
            unique case (mul_op)
              MUL_LEN: begin
                mul_op <= MUL_DOT;
                state  <= S_MUL_GO;
              end
              MUL_DOT: begin
                mul_op <= MUL_OPEN;
                state  <= S_MUL_GO;
              end
              MUL_OPEN: begin
                mul_op <= MUL_CLOSED;
                state  <= S_MUL_GO;
              end
              MUL_CLOSED: state <= S_DECIDE;
              default:    state <= S_DECIDE;
            endcase
          end
        end
        S_DECIDE: begin
          if (cmd.decide) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A new result appears only out of the decision step
  a_result_from_decide: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_DECIDE))
    else $error("result valid rose outside the decision step");

  // The multiplier is quiet whenever requests are taken
  a_mul_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !stat.mul_busy)
    else $error("multiplier busy while idle");

  // A finished multiply moves on to the next one or to the decision
  a_mul_advance: assert property (@(posedge clk) disable iff (rst)
    (state == S_MUL_WAIT && !stat.mul_busy) |=> (state == S_MUL_GO || state == S_DECIDE))
    else $error("sequencer stuck after a multiply");

  // A waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.decide && stat.pinky) |-> !(out_valid && out_stall))
    else $error("result register loaded while still held");

endmodule

// ----- rtl/core/hand_pose_classifier_top.sv -----
// Top level of the hand pose classifier: controller plus datapath.
// A metacarpal bone is taken without leaving the idle state; an intermediate bone holds off
// the input while the controller steps through the dot, length and sum states and four serial multiplies.
// The result is registered in the decision step after the pinky intermediate bone is taken; that step
// waits while an earlier result is still stalled at the output, which also holds off the input.
// Synchronous reset loads the default thresholds and clears base direction and flags.
module hand_pose_classifier_top #(
  parameter int COORD_BITS = hpc_pkg::COORD_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [hpc_pkg::CFG_INDEX_W-1:0]       cfg_index,
  input  logic [hpc_pkg::THR_W-1:0]             cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [1:0]                            finger_index,
  input  logic                                  bone_kind,
  input  logic signed [COORD_BITS-1:0]          start_x,
  input  logic signed [COORD_BITS-1:0]          start_y,
  input  logic signed [COORD_BITS-1:0]          start_z,
  input  logic signed [COORD_BITS-1:0]          end_x,
  input  logic signed [COORD_BITS-1:0]          end_y,
  input  logic signed [COORD_BITS-1:0]          end_z,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [2:0]                            gesture_code,
  output logic [hpc_pkg::FINGERS-1:0]           open_mask,
  output logic [hpc_pkg::FINGERS-1:0]           closed_mask
);

  import hpc_pkg::*;

  hpc_cmd_t  cmd;
  hpc_stat_t stat;

  hpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .bone_kind (bone_kind),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  hpc_dpath #(
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .finger_index (finger_index),
    .start_x      (start_x),
    .start_y      (start_y),
    .start_z      (start_z),
    .end_x        (end_x),
    .end_y        (end_y),
    .end_z        (end_z),
    .gesture_code (gesture_code),
    .open_mask    (open_mask),
    .closed_mask  (closed_mask)
  );

endmodule

// ----- test/tb_top.sv -----
// Self-checking testbench for the hand pose classifier: random hands against a local predictor.
module tb_top;
  import hpc_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SETTLE_CYCLES = 64;
  localparam int ITEMS_PER_PHASE = 240;
  localparam int PHASES = 8;

  // One bone request plus its idle gap and whether to wait for open results first
  typedef struct {
    logic [1:0] finger;
    logic kind;
    logic signed [15:0] sx, sy, sz, ex, ey, ez;
    int gap;
    bit hold;
  } bone_t;

  // Gesture and masks for one finished hand
  typedef struct {
    gesture_t gesture;
    logic [3:0] open_m;
    logic [3:0] closed_m;
  } pose_t;

  // Finger shapes used to build hands
  typedef enum int {SHAPE_OPEN, SHAPE_CLOSED, SHAPE_BENT, SHAPE_ANY, SHAPE_FLAT,
                    SHAPE_RANDOM} finger_shape_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [THR_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] finger_index = '0;
  logic bone_kind = 1'b0;
  logic signed [15:0] start_x = '0, start_y = '0, start_z = '0;
  logic signed [15:0] end_x = '0, end_y = '0, end_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] gesture_code;
  logic [FINGERS-1:0] open_mask;
  logic [FINGERS-1:0] closed_mask;

  bone_t bone_q[$];
  pose_t pending_poses[$];
  bone_t cur_bone;
  bit bone_loaded = 1'b0;
  bit bone_shown = 1'b0;
  int gap_left = 0;
  bit bone_taken = 1'b0;
  bit pose_taken = 1'b0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit rx_armed = 1'b0;
  int stall_left = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int mismatch_count = 0;
  int phase_items = 0;

  // Predictor state
  logic signed [15:0] open_thr, closed_thr;
  longint base_dir[3];
  logic [3:0] open_bits, closed_bits;

  hand_pose_classifier_top u_top (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .finger_index(finger_index), .bone_kind(bone_kind),
    .start_x(start_x), .start_y(start_y), .start_z(start_z),
    .end_x(end_x), .end_y(end_y), .end_z(end_z),
    .out_valid(out_valid), .out_stall(out_stall),
    .gesture_code(gesture_code), .open_mask(open_mask), .closed_mask(closed_mask)
  );

  always #1 clk = ~clk;

  task automatic flag_mismatch(string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  function automatic void clear_hand();
    base_dir = '{0, 0, 0};
    open_bits = '0;
    closed_bits = '0;
  endfunction

  // Exact test of dot / sqrt(len_sq) > thr / 32768 by signs and squares
  function automatic bit cos_exceeds(longint dot, logic [127:0] len_sq, longint thr);
    logic [63:0] dm, tm;
    logic [127:0] lhs, rhs;
    if (dot >= 0 && thr < 0) return 1'b1;
    if (dot < 0 && thr >= 0) return 1'b0;
    dm = (dot < 0) ? -dot : dot;
    tm = (thr < 0) ? -thr : thr;
    lhs = ({64'b0, dm} * {64'b0, dm}) << 30;
    rhs = {64'b0, tm} * {64'b0, tm} * len_sq;
    return (dot >= 0) ? (lhs > rhs) : (lhs < rhs);
  endfunction

  // Update finger flags for one bone; a pinky intermediate closes the hand
  task automatic classify_bone(bone_t b);
    longint dir[3];
    longint dot;
    logic [63:0] la, lb;
    logic [127:0] len_sq;
    bit is_open, is_closed;
    pose_t res;
    int i;
    dir[0] = longint'(b.ex) - longint'(b.sx);
    dir[1] = longint'(b.ey) - longint'(b.sy);
    dir[2] = longint'(b.ez) - longint'(b.sz);
    if (b.kind == BONE_METACARPAL) begin
      base_dir = dir;
    end else begin
      dot = 0;
      la = '0;
      lb = '0;
      is_open = 1'b0;
      is_closed = 1'b0;
      for (i = 0; i < 3; i++) begin
        dot += base_dir[i] * dir[i];
        la += 64'(base_dir[i] * base_dir[i]);
        lb += 64'(dir[i] * dir[i]);
      end
      // a zero-length bone on either side leaves the finger neither open nor closed
      if (la != 0 && lb != 0) begin
        len_sq = {64'b0, la} * {64'b0, lb};
        is_open = cos_exceeds(dot, len_sq, longint'(open_thr));
        is_closed = cos_exceeds(-dot, len_sq, -longint'(closed_thr));
      end
      open_bits[b.finger] = is_open;
      closed_bits[b.finger] = is_closed;
      if (b.finger == FINGER_PINKY) begin
        if (open_bits == 4'hF) res.gesture = GEST_OPEN;
        else if (closed_bits == 4'hF) res.gesture = GEST_CLOSED;
        else if (open_bits == 4'b0001) res.gesture = GEST_OPEN_INDEX;
        else if (open_bits == 4'b0000 && !closed_bits[0]) res.gesture = GEST_CURVED_INDEX;
        else if (open_bits == 4'b0011) res.gesture = GEST_INDEX_MIDDLE;
        else if (open_bits == 4'b0111) res.gesture = GEST_INDEX_MIDDLE_RING;
        else if (open_bits[2:0] == 3'b000 && !closed_bits[3]) res.gesture = GEST_PINKY;
        else res.gesture = GEST_NONE;
        res.open_m = open_bits;
        res.closed_m = closed_bits;
        pending_poses.push_back(res);
        clear_hand();
      end
    end
  endtask

  // Check results, track config writes, predict accepted requests
  always @(posedge clk) begin : pose_monitor
    pose_t want;
    bone_t seen;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      bone_taken = !rst && in_valid && !in_stall;
      pose_taken = !rst && out_valid && !out_stall;
      if (rst) begin
        open_thr = OPEN_COS_RESET;
        closed_thr = CLOSED_COS_RESET;
        clear_hand();
      end else begin
        if (pose_taken) begin
          if (pending_poses.size() == 0) begin
            flag_mismatch("result with no hand pending");
          end else begin
            want = pending_poses.pop_front();
            if (gesture_code !== want.gesture)
              flag_mismatch($sformatf("gesture_code %0d, want %0d", gesture_code, want.gesture));
            if (open_mask !== want.open_m)
              flag_mismatch($sformatf("open_mask %b, want %b", open_mask, want.open_m));
            if (closed_mask !== want.closed_m)
              flag_mismatch($sformatf("closed_mask %b, want %b", closed_mask, want.closed_m));
          end
        end
        if (cfg_we) begin
          case (cfg_index)
            REG_OPEN_COS: open_thr = cfg_data;
            REG_CLOSED_COS: closed_thr = cfg_data;
            default: ;
          endcase
        end
        if (bone_taken) begin
          seen.finger = finger_index;
          seen.kind = bone_kind;
          seen.sx = start_x;
          seen.sy = start_y;
          seen.sz = start_z;
          seen.ex = end_x;
          seen.ey = end_y;
          seen.ez = end_z;
          classify_bone(seen);
        end
      end
    end
  end

  // Present queued requests after their gap; hold each until taken
  always @(negedge clk) begin
    if (!rst) begin
      if (bone_loaded && bone_taken) bone_loaded = 1'b0;
      if (!bone_loaded && bone_q.size() != 0) begin
        cur_bone = bone_q.pop_front();
        bone_loaded = 1'b1;
        bone_shown = 1'b0;
        gap_left = cur_bone.gap;
      end
      if (bone_loaded && !bone_shown) begin
        if (gap_left != 0) gap_left--;
        else if (!cur_bone.hold || pending_poses.size() == 0) bone_shown = 1'b1;
      end
      in_valid <= bone_loaded && bone_shown;
      if (bone_loaded) begin
        finger_index <= cur_bone.finger;
        bone_kind <= cur_bone.kind;
        start_x <= cur_bone.sx;
        start_y <= cur_bone.sy;
        start_z <= cur_bone.sz;
        end_x <= cur_bone.ex;
        end_y <= cur_bone.ey;
        end_z <= cur_bone.ez;
      end
    end
  end

  // Stall each result a random number of cycles; toggle stall at random while idle
  always @(negedge clk) begin
    if (!rst) begin
      if (pose_taken) begin
        rx_armed = 1'b0;
        results_seen++;
        if (results_seen % 8 == 0) rx_quiet = ($urandom_range(0, 3) == 0);
      end
      if (!rx_armed && out_valid === 1'b1) begin
        rx_armed = 1'b1;
        stall_left = rx_quiet ? 0 : $urandom_range(0, 19);
      end
      if (rx_armed) begin
        out_stall <= (stall_left != 0);
        if (stall_left != 0) stall_left--;
      end else begin
        out_stall <= !rx_quiet && ($urandom_range(0, 1) == 1);
      end
    end
  end

  function automatic bone_t bone_at(logic [1:0] f, logic k, int sx, int sy, int sz,
                                    int ex, int ey, int ez);
    bone_t b;
    b.finger = f;
    b.kind = k;
    b.sx = 16'(sx);
    b.sy = 16'(sy);
    b.sz = 16'(sz);
    b.ex = 16'(ex);
    b.ey = 16'(ey);
    b.ez = 16'(ez);
    b.gap = 0;
    b.hold = 1'b0;
    return b;
  endfunction

  // Pick a start so that start + d stays in the 16-bit range
  function automatic int start_for(int d);
    int lo, hi;
    lo = (d < 0) ? -32768 - d : -32768;
    hi = (d < 0) ? 32767 : 32767 - d;
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic bone_t bone_along(logic [1:0] f, logic k, int d[3]);
    int s[3];
    int i;
    for (i = 0; i < 3; i++) s[i] = start_for(d[i]);
    return bone_at(f, k, s[0], s[1], s[2], s[0] + d[0], s[1] + d[1], s[2] + d[2]);
  endfunction

  function automatic int rand_axis(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic bone_t noise_bone();
    return bone_at(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                   $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  task automatic queue_bone(bone_t b, bit hold);
    b.gap = tx_quiet ? 0 : $urandom_range(0, 19);
    b.hold = hold;
    bone_q.push_back(b);
    phase_items++;
  endtask

  // Build one hand; random hands may be broken by drops, repeats, swaps or noise
  task automatic queue_hand(finger_shape_t shape, bit hold);
    bone_t hand[$];
    bone_t tmp;
    finger_shape_t fs;
    int a[3], b[3];
    int f, i, j, r, span, nspan, m;
    if ($urandom_range(0, 7) == 0) tx_quiet = !tx_quiet;
    for (f = 0; f < FINGERS; f++) begin
      fs = shape;
      if (shape == SHAPE_RANDOM) begin
        r = $urandom_range(0, 19);
        fs = (r < 6) ? SHAPE_OPEN : (r < 12) ? SHAPE_CLOSED : (r < 16) ? SHAPE_ANY :
             (r < 19) ? SHAPE_BENT : SHAPE_FLAT;
      end
      case ($urandom_range(0, 3))
        0: span = 8;
        1: span = 300;
        2: span = 4000;
        default: span = 8000;
      endcase
      nspan = ($urandom_range(0, 3) == 0) ? 0 : span / 16;
      m = $urandom_range(1, 4);
      for (i = 0; i < 3; i++) a[i] = rand_axis(span);
      for (i = 0; i < 3; i++) begin
        case (fs)
          SHAPE_OPEN: b[i] = a[i] * m / 2 + rand_axis(nspan);
          SHAPE_CLOSED: b[i] = -(a[i] * m / 2) + rand_axis(nspan);
          SHAPE_BENT: b[i] = ((i == 0) ? -a[1] : (i == 1) ? a[0] : 0) + rand_axis(nspan);
          default: b[i] = rand_axis(span);
        endcase
      end
      // zero out one of the two bones
      if (fs == SHAPE_FLAT) begin
        if ($urandom_range(0, 1) == 1) a = '{0, 0, 0};
        else b = '{0, 0, 0};
      end
      hand.push_back(bone_along(2'(f), BONE_METACARPAL, a));
      hand.push_back(bone_along(2'(f), BONE_INTERMEDIATE, b));
    end
    if (shape == SHAPE_RANDOM) begin
      r = $urandom_range(0, 11);
      case (r)
        7: hand.delete($urandom_range(0, hand.size() - 1));
        8: begin
          i = $urandom_range(0, hand.size() - 1);
          hand.insert($urandom_range(0, hand.size()), hand[i]);
        end
        9: begin
          i = $urandom_range(0, hand.size() - 1);
          j = $urandom_range(0, hand.size() - 1);
          tmp = hand[i];
          hand[i] = hand[j];
          hand[j] = tmp;
        end
        10, 11: begin
          m = $urandom_range(1, 4);
          for (i = 0; i < m; i++) hand.insert($urandom_range(0, hand.size()), noise_bone());
        end
        default: ;
      endcase
    end
    for (i = 0; i < hand.size(); i++) queue_bone(hand[i], hold && i == 0);
  endtask

  task automatic write_threshold(logic [CFG_INDEX_W-1:0] idx, logic [THR_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for every request and result, then let the block finish its work
  task automatic settle();
    while (bone_q.size() != 0 || bone_loaded || pending_poses.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int phase;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    for (phase = 0; phase < PHASES; phase++) begin
      phase_items = 0;
      case (phase)
        0: begin
          // intermediate with no metacarpal since reset
          queue_bone(bone_at(0, BONE_INTERMEDIATE, 10, 20, 30, 50, -40, 90), 1'b0);
          // zero-length metacarpal
          queue_bone(bone_at(1, BONE_METACARPAL, 100, 100, 100, 100, 100, 100), 1'b0);
          queue_bone(bone_at(1, BONE_INTERMEDIATE, 0, 0, 0, 64, 0, 0), 1'b0);
          // full-range coordinates, exactly opposite bones
          queue_bone(bone_at(2, BONE_METACARPAL, -32768, -32768, -32768,
                             32767, 32767, 32767), 1'b0);
          queue_bone(bone_at(2, BONE_INTERMEDIATE, 32767, 32767, 32767,
                             -32768, -32768, -32768), 1'b0);
          // zero-length intermediate on the pinky
          queue_bone(bone_at(3, BONE_METACARPAL, 0, 0, 0, 16, 0, 0), 1'b0);
          queue_bone(bone_at(3, BONE_INTERMEDIATE, -5, 7, 9, -5, 7, 9), 1'b0);
          queue_hand(SHAPE_OPEN, 1'b1);
          queue_hand(SHAPE_CLOSED, 1'b0);
        end
        1: begin
          write_threshold(REG_OPEN_COS, 16'h7FFF);
          write_threshold(REG_CLOSED_COS, 16'h8000);
        end
        2: begin
          write_threshold(REG_OPEN_COS, 16'h8000);
          write_threshold(REG_CLOSED_COS, 16'h7FFF);
        end
        3: begin
          write_threshold(REG_OPEN_COS, 16'h0000);
          write_threshold(REG_CLOSED_COS, 16'h0000);
        end
        5: begin
          write_threshold(REG_OPEN_COS, 16'($urandom));
          write_threshold(REG_CLOSED_COS, 16'($urandom));
        end
        7: begin
          write_threshold(REG_OPEN_COS, OPEN_COS_RESET);
          write_threshold(REG_CLOSED_COS, CLOSED_COS_RESET);
        end
        default: begin
          write_threshold(REG_OPEN_COS, 16'($urandom_range(0, 32767)));
          write_threshold(REG_CLOSED_COS, 16'(-int'($urandom_range(1, 32768))));
        end
      endcase
      while (phase_items < ITEMS_PER_PHASE)
        queue_hand(SHAPE_RANDOM, $urandom_range(0, 29) == 0);
      settle();
    end
    if (mismatch_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/hpc_pkg.sv
rtl/core/hpc_serial_mul.sv
rtl/core/hpc_dpath.sv
rtl/core/hpc_ctrl.sv
rtl/core/hand_pose_classifier_top.sv
test/tb_top.sv
